[sv/ifse_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and the stuffing function of the information frame encoder.
package ifse_pkg;

  localparam logic [7:0] FRAME_FLAG     = 8'h7E;
  localparam logic [7:0] ESCAPE_BYTE    = 8'h7D;
  localparam logic [7:0] ESCAPED_FLAG   = 8'h5E;
  localparam logic [7:0] ESCAPED_ESCAPE = 8'h5D;

  // Longest burst one input beat can cause: header, stuffed data, stuffed BCC2, flag.
  localparam int MAX_BYTES = 9;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  localparam logic [1:0] REG_ADDRESS   = 2'd0;
  localparam logic [1:0] REG_CTRL_ZERO = 2'd1;
  localparam logic [1:0] REG_CTRL_ONE  = 2'd2;

  typedef struct packed {
    logic       two;
    logic [7:0] b1;
    logic [7:0] b0;
  } stuff_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      closes;
  } burst_t;

  function automatic stuff_t stuff(input logic [7:0] v);
    stuff_t s;
    s.two = 1'b0;
    s.b0  = v;
    s.b1  = ESCAPED_FLAG;
    if (v == FRAME_FLAG) begin
      s.two = 1'b1;
      s.b0  = ESCAPE_BYTE;
      s.b1  = ESCAPED_FLAG;
    end else if (v == ESCAPE_BYTE) begin
      s.two = 1'b1;
      s.b0  = ESCAPE_BYTE;
      s.b1  = ESCAPED_ESCAPE;
    end
    return s;
  endfunction

endpackage

[sv/ifse_pack.sv]
`timescale 1ns / 1ps
// Builds the burst of line bytes that one payload beat produces.
module ifse_pack (
  input  logic [7:0]       payload_byte,
  input  logic             final_byte,
  input  logic             sequence_bit,
  input  logic             inside_frame,
  input  logic [7:0]       payload_xor,
  input  logic [7:0]       address_byte,
  input  logic [7:0]       control_seq_zero,
  input  logic [7:0]       control_seq_one,
  output ifse_pkg::burst_t burst,
  output logic [7:0]       xor_nxt
);

  logic [7:0]                 ctrl;
  logic [7:0]                 bcc2;
  logic [ifse_pkg::CNT_W-1:0] n;
  ifse_pkg::stuff_t           sd;
  ifse_pkg::stuff_t           sb;

  assign ctrl = sequence_bit ? control_seq_one : control_seq_zero;
  // A new frame starts its running XOR from zero.
  assign bcc2 = (inside_frame ? payload_xor : 8'h00) ^ payload_byte;
  assign xor_nxt = bcc2;
  assign sd = ifse_pkg::stuff(payload_byte);
  assign sb = ifse_pkg::stuff(bcc2);

  always_comb begin
    burst = '0;
    n     = '0;
    if (!inside_frame) begin
      burst.bytes[0] = ifse_pkg::FRAME_FLAG;
      burst.bytes[1] = address_byte;
      burst.bytes[2] = ctrl;
      burst.bytes[3] = address_byte ^ ctrl;
      n = ifse_pkg::CNT_W'(4);
    end
    burst.bytes[n] = sd.b0;
    n = n + ifse_pkg::CNT_W'(1);
    if (sd.two) begin
      burst.bytes[n] = sd.b1;
      n = n + ifse_pkg::CNT_W'(1);
    end
    if (final_byte) begin
      burst.bytes[n] = sb.b0;
      n = n + ifse_pkg::CNT_W'(1);
      if (sb.two) begin
        burst.bytes[n] = sb.b1;
        n = n + ifse_pkg::CNT_W'(1);
      end
      burst.bytes[n] = ifse_pkg::FRAME_FLAG;
      n = n + ifse_pkg::CNT_W'(1);
      burst.closes = 1'b1;
    end
    burst.cnt = n;
  end

endmodule

[sv/info_frame_stuffing_encoder.sv]
`timescale 1ns / 1ps
// Information frame encoder: takes one payload byte per beat and sends a byte-stuffed
// frame, one line byte per beat. The first byte of a frame brings the opening flag,
// address, control byte (picked by in_tuser) and BCC1; the beat marked in_tlast adds the
// stuffed BCC2 and the closing flag, marked by out_tuser. An input beat produces 1 or 2 line
// bytes for a byte in the middle of a frame, up to 6 for the first byte of a frame, up to 5
// for its final byte and up to 9 for a one-byte frame. The output register moves one line
// byte per cycle while out_tready does not stall it; the next input beat is taken in the
// same cycle the last byte of the previous burst moves to the output register.
// Configuration takes effect at the next frame header.
module info_frame_stuffing_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] payload_byte
  input  logic       in_tlast,   // final_byte
  input  logic       in_tuser,   // [0] sequence_bit
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] line_byte
  output logic       out_tlast,  // run_last
  output logic       out_tuser,  // [0] frame_closed
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] address_r;
  logic [7:0] ctrl_zero_r;
  logic [7:0] ctrl_one_r;
  logic       inside_r;
  logic [7:0] xor_r;

  logic [ifse_pkg::MAX_BYTES-1:0][7:0] bytes_r;
  logic [ifse_pkg::MAX_BYTES-1:0][7:0] bytes_nxt;
  logic [ifse_pkg::CNT_W-1:0]          cnt_r;
  logic [ifse_pkg::CNT_W-1:0]          cnt_nxt;
  logic                                close_r;

  logic       out_tvalid_r;
  logic [7:0] out_tdata_r;
  logic       out_tlast_r;
  logic       out_tuser_r;

  ifse_pkg::burst_t burst;
  logic [7:0]       xor_nxt;
  logic             pop;
  logic             accept;

  ifse_pack u_pack (
    .payload_byte     (in_tdata),
    .final_byte       (in_tlast),
    .sequence_bit     (in_tuser),
    .inside_frame     (inside_r),
    .payload_xor      (xor_r),
    .address_byte     (address_r),
    .control_seq_zero (ctrl_zero_r),
    .control_seq_one  (ctrl_one_r),
    .burst            (burst),
    .xor_nxt          (xor_nxt)
  );

  assign pop       = (cnt_r != '0) && (!out_tvalid_r || out_tready);
  assign in_tready = (cnt_r == '0) || ((cnt_r == ifse_pkg::CNT_W'(1)) && pop);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    if (pop) begin
      for (int i = 0; i < ifse_pkg::MAX_BYTES - 1; i++) begin
        bytes_nxt[i] = bytes_r[i+1];
      end
      cnt_nxt = cnt_r - ifse_pkg::CNT_W'(1);
    end
    if (accept) begin
      bytes_nxt = burst.bytes;
      cnt_nxt   = burst.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r    <= 8'd3;
      ctrl_zero_r  <= 8'd0;
      ctrl_one_r   <= 8'd128;
      inside_r     <= 1'b0;
      xor_r        <= 8'h00;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          ifse_pkg::REG_ADDRESS:   address_r   <= cfg_wdata;
          ifse_pkg::REG_CTRL_ZERO: ctrl_zero_r <= cfg_wdata;
          ifse_pkg::REG_CTRL_ONE:  ctrl_one_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        inside_r <= !in_tlast;
        xor_r    <= in_tlast ? 8'h00 : xor_nxt;
      end
      cnt_r <= cnt_nxt;
      if (pop) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (accept) begin
      close_r <= burst.closes;
    end
    if (pop) begin
      out_tdata_r <= bytes_r[0];
      out_tlast_r <= (cnt_r == ifse_pkg::CNT_W'(1));
      out_tuser_r <= close_r && (cnt_r == ifse_pkg::CNT_W'(1));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ifse_pkg::CNT_W'(ifse_pkg::MAX_BYTES))
    else $error("burst count beyond the longest burst");

  a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (cnt_r <= ifse_pkg::CNT_W'(1)))
    else $error("input beat taken while a burst is still pending");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (cnt_r != '0))
    else $error("accepted beat left no line bytes");

  a_close_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && out_tdata == ifse_pkg::FRAME_FLAG))
    else $error("closing flag not at the end of its burst");
`endif

endmodule
